FILE: rtl/core/aging_priority_task_buffer_macros.svh
// Assertion macros used by the task buffer back end.
// Every macro expects signals named clk and arst_n in the using scope.
`ifndef AGING_PRIORITY_TASK_BUFFER_MACROS_SVH
`define AGING_PRIORITY_TASK_BUFFER_MACROS_SVH

// Same-cycle implication, checked at each clock edge outside reset.
`define APT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at each clock edge outside reset.
`define APT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/apt_pkg.sv
// Types and constants of the aging priority task buffer.
// No dependencies; imported by every module, but not by the interfaces or the macro header.
package apt_pkg;
	localparam int DEPTH_DEF      = 20;
	localparam int ACCEPT_MAX_DEF = 10;
	localparam int RES_LIMIT      = 20;
	localparam logic [3:0] AGE_MAX = 4'd15;
	localparam logic [3:0] THR_RST = 4'd3;

	localparam logic CFG_AGE_THRESHOLD = 1'b0;
	localparam logic CFG_SMALL_FIRST   = 1'b1;

	localparam logic REQ_INSERT   = 1'b0;
	localparam logic REQ_DISPATCH = 1'b1;

	typedef struct packed {
		logic        dispatch;
		logic [31:0] weight;
		logic [4:0]  cnt;
	} apt_item_t;

	typedef struct packed {
		logic [3:0] age_threshold;
		logic       small_first;
	} apt_cfg_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_PICK
	} apt_bstate_t;
endpackage

FILE: rtl/core/apt_req_if.sv
// Request channel: valid/ready handshake with the input word fields.
// Depends on nothing.
interface apt_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] weight;
	logic [4:0]  ready_count;

	modport source (output valid, req_type, weight, ready_count, input ready);
	modport sink (input valid, req_type, weight, ready_count, output ready);
endinterface

FILE: rtl/core/apt_res_if.sv
// Result channel: valid/ready handshake with the result word fields.
// Depends on nothing.
interface apt_res_if;
	logic        valid;
	logic        ready;
	logic        has_task;
	logic [31:0] out_weight;
	logic        last;
	logic [3:0]  free_slots;
	logic [3:0]  drop_count;
	logic        insert_dropped;

	modport source (output valid, has_task, out_weight, last, free_slots, drop_count,
		insert_dropped, input ready);
	modport sink (input valid, has_task, out_weight, last, free_slots, drop_count,
		insert_dropped, output ready);
endinterface

FILE: rtl/core/apt_front.sv
// Front end: accepts request words, classifies them and clips the dispatch count.
// Depends on apt_pkg and apt_req_if.
module apt_front import apt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	apt_req_if.sink    req,
	output logic       push,
	output apt_item_t  item,
	input  logic       full
);
	logic      v_s1;
	apt_item_t item_s1;

	assign req.ready = !v_s1 || !full;
	assign push      = v_s1 && !full;
	assign item      = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.dispatch <= (req.req_type == REQ_DISPATCH);
			item_s1.weight   <= req.weight;
			item_s1.cnt      <= (req.ready_count > 5'(RES_LIMIT)) ? 5'(RES_LIMIT)
				: req.ready_count;
		end
	end
endmodule

FILE: rtl/core/apt_fifo.sv
// Two-entry queue of classified requests between the front and back ends.
// Depends on apt_pkg.
module apt_fifo import apt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  apt_item_t din,
	output logic      full,
	input  logic      pop,
	output apt_item_t dout,
	output logic      empty
);
	apt_item_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end
endmodule

FILE: rtl/core/apt_back.sv
// Back end: task slots, selection scan, removal, aging and the result register.
// Depends on apt_pkg, apt_res_if and the assertion macro header.
`include "aging_priority_task_buffer_macros.svh"
module apt_back import apt_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ACCEPT_MAX = ACCEPT_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  apt_cfg_t  cfg,
	input  apt_item_t item,
	input  logic      empty,
	output logic      pop,
	apt_res_if.source res
);
	localparam int OW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int NW = (OW > 5) ? OW : 5;

	logic [31:0] w_q [DEPTH];
	logic [3:0]  a_q [DEPTH];
	logic [OW-1:0] occ_q, occ_fin_q;
	logic [NW-1:0] rem_q;
	logic [IW-1:0] idx_q, bidx_q;
	logic [31:0]   bw_q;
	logic [3:0]    ba_q;
	apt_bstate_t   st_q, st_d;

	logic        ov_q, o_has_q, o_last_q, o_drop_q;
	logic [31:0] o_w_q;
	logic [3:0]  o_fs_q, o_dc_q;

	logic          can_load, cand_first;
	logic [NW-1:0] n_disp;
	logic [OW-1:0] st_occ;
	logic [3:0]    st_fs, st_dc;
	int            empty_slots;

	assign can_load = !ov_q || res.ready;
	assign n_disp = (NW'(item.cnt) < NW'(occ_q)) ? NW'(item.cnt) : NW'(occ_q);

	// The candidate wins on age class first, then on weight; a tie keeps the earlier slot.
	always_comb begin
		logic ca, ba;
		ca = (a_q[idx_q] >= cfg.age_threshold);
		ba = (ba_q >= cfg.age_threshold);
		if (idx_q == '0) cand_first = 1'b1;
		else if (ca != ba) cand_first = ca;
		else if (cfg.small_first) cand_first = w_q[idx_q] < bw_q;
		else cand_first = w_q[idx_q] > bw_q;
	end

	// Status is reported for the occupancy after the whole request.
	always_comb begin
		if (st_q == B_IDLE) begin
			if (item.dispatch) st_occ = occ_q;
			else st_occ = (occ_q < OW'(DEPTH)) ? occ_q + OW'(1) : occ_q;
		end else begin
			st_occ = occ_fin_q;
		end
		empty_slots = DEPTH - int'(st_occ);
		if (empty_slots < ACCEPT_MAX) begin
			st_fs = 4'(empty_slots);
			st_dc = 4'(ACCEPT_MAX - empty_slots);
		end else begin
			st_fs = 4'(ACCEPT_MAX);
			st_dc = 4'd0;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: if (!empty && can_load && item.dispatch && n_disp != '0) st_d = B_SCAN;
			else if (!empty && item.dispatch && n_disp != '0) st_d = B_SCAN;
			B_SCAN: if (OW'(idx_q) + OW'(1) >= occ_q) st_d = B_PICK;
			B_PICK: if (can_load) st_d = (rem_q == NW'(1)) ? B_IDLE : B_SCAN;
			default: st_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		case (st_q)
			B_IDLE: pop = !empty && (can_load || (item.dispatch && n_disp != '0));
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= B_IDLE;
			occ_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (res.ready) ov_q <= 1'b0;
			if (st_q == B_IDLE && pop) begin
				if (!item.dispatch) begin
					if (occ_q < OW'(DEPTH)) occ_q <= occ_q + OW'(1);
					ov_q <= 1'b1;
				end else if (n_disp == '0) begin
					ov_q <= 1'b1;
				end
			end
			if (st_q == B_PICK && can_load) begin
				occ_q <= occ_q - OW'(1);
				ov_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: if (pop) begin
				// A dispatch with tasks may start while an older word still waits.
				if (!item.dispatch || n_disp == '0) begin
					o_has_q  <= 1'b0;
					o_w_q    <= '0;
					o_last_q <= 1'b1;
					o_fs_q   <= st_fs;
					o_dc_q   <= st_dc;
					o_drop_q <= !item.dispatch && (occ_q >= OW'(DEPTH));
				end
				idx_q     <= '0;
				rem_q     <= n_disp;
				occ_fin_q <= occ_q - OW'(n_disp);
				if (!item.dispatch) begin
					if (occ_q < OW'(DEPTH)) begin
						w_q[IW'(occ_q)] <= item.weight;
						a_q[IW'(occ_q)] <= '0;
					end
				end else if (n_disp == '0) begin
					for (int i = 0; i < DEPTH; i++)
						if (a_q[i] != AGE_MAX) a_q[i] <= a_q[i] + 4'd1;
				end
			end
			B_SCAN: begin
				if (cand_first) begin
					bw_q   <= w_q[idx_q];
					ba_q   <= a_q[idx_q];
					bidx_q <= idx_q;
				end
				idx_q <= idx_q + IW'(1);
			end
			B_PICK: if (can_load) begin
				o_has_q  <= 1'b1;
				o_w_q    <= bw_q;
				o_last_q <= (rem_q == NW'(1));
				o_fs_q   <= st_fs;
				o_dc_q   <= st_dc;
				o_drop_q <= 1'b0;
				rem_q    <= rem_q - NW'(1);
				idx_q    <= '0;
				// Close the gap left by the picked slot; the final pick also ages the rest.
				for (int i = 0; i < DEPTH; i++) begin
					logic [31:0] nw;
					logic [3:0]  na;
					if (i >= int'(bidx_q) && i < DEPTH - 1) begin
						nw = w_q[i+1];
						na = a_q[i+1];
					end else begin
						nw = w_q[i];
						na = a_q[i];
					end
					w_q[i] <= nw;
					if (rem_q == NW'(1) && na != AGE_MAX) a_q[i] <= na + 4'd1;
					else a_q[i] <= na;
				end
			end
			default: ;
		endcase
	end

	assign res.valid          = ov_q;
	assign res.has_task       = o_has_q;
	assign res.out_weight     = o_w_q;
	assign res.last           = o_last_q;
	assign res.free_slots     = o_fs_q;
	assign res.drop_count     = o_dc_q;
	assign res.insert_dropped = o_drop_q;

	`APT_ASSERT_NOW(a_occ_range, 1'b1, occ_q <= OW'(DEPTH), "occupancy above depth")
	`APT_ASSERT_NOW(a_pick_idx, st_q == B_PICK, OW'(bidx_q) < occ_q, "picked slot not valid")
	`APT_ASSERT_NOW(a_empty_last, ov_q && !o_has_q, o_last_q, "empty result without last")
	`APT_ASSERT_NEXT(a_pick_done, st_q == B_PICK && can_load && rem_q == NW'(1),
		st_q == B_IDLE, "dispatch did not finish")
endmodule

FILE: rtl/core/aging_priority_task_buffer.sv
// Aging priority task buffer: an insert or empty dispatch passes the front stage, the queue
// and the result register; inserts can be taken one word per cycle while no dispatch runs
// and the result channel is ready. Each dispatched word takes a scan over every occupied
// slot, then the pick, which waits while the result register holds a word not yet taken.
// The front stage and two-entry queue take up to three more words while a dispatch runs.
// Reset clears occupancy, queue and result valid; threshold 3, smallest first.
module aging_priority_task_buffer import apt_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ACCEPT_MAX = ACCEPT_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [3:0] cfg_data,
	apt_req_if.sink    req,
	apt_res_if.source  res
);
	apt_cfg_t  cfg_q;
	apt_item_t f_item, q_item;
	logic      f_push, q_full, q_empty, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.age_threshold <= THR_RST;
			cfg_q.small_first   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_AGE_THRESHOLD: cfg_q.age_threshold <= cfg_data;
				CFG_SMALL_FIRST:   cfg_q.small_first   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	apt_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.push(f_push), .item(f_item), .full(q_full)
	);

	apt_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(f_push), .din(f_item), .full(q_full),
		.pop(q_pop), .dout(q_item), .empty(q_empty)
	);

	apt_back #(.DEPTH(DEPTH), .ACCEPT_MAX(ACCEPT_MAX)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .item(q_item),
		.empty(q_empty), .pop(q_pop), .res(res)
	);
endmodule

FILE: tb/aging_buffer_checker.sv
// Checker for the aging priority task buffer: predicts every result word from the
// request words accepted on the channels and compares. Depends on apt_pkg and the
// two channel interfaces.
module aging_buffer_checker import apt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_idx,
	input  logic [3:0] cfg_data,
	apt_req_if.sink   req_mon,
	apt_res_if.sink   res_mon,
	output int        fail_count,
	output int        pending,
	output int        task_results
);
	typedef struct packed {
		logic        has_task;
		logic [31:0] out_weight;
		logic        last;
		logic [3:0]  free_slots;
		logic [3:0]  drop_count;
		logic        insert_dropped;
	} result_word_t;

	logic [31:0]  buf_weight[20];
	logic [3:0]   buf_age[20];
	int           buf_fill;
	logic [3:0]   thr;
	logic         smallest;
	result_word_t expected_words[$];

	assign pending = expected_words.size();

	function automatic bit leaves_first(int i, int j);
		bit ai, aj;
		ai = buf_age[i] >= thr;
		aj = buf_age[j] >= thr;
		if (ai != aj)
			return ai;
		if (smallest)
			return buf_weight[i] < buf_weight[j];
		return buf_weight[i] > buf_weight[j];
	endfunction

	function automatic result_word_t status_word(bit has, logic [31:0] w, bit lst, bit drp);
		result_word_t r;
		int empty;
		empty = 20 - buf_fill;
		r.has_task = has;
		r.out_weight = w;
		r.last = lst;
		r.free_slots = (empty < 10) ? empty[3:0] : 4'd10;
		r.drop_count = (empty < 10) ? 4'(10 - empty) : 4'd0;
		r.insert_dropped = drp;
		return r;
	endfunction

	task automatic queue_word(result_word_t word);
		expected_words = {expected_words, word};
	endtask

	task automatic predict_request(logic kind, logic [31:0] w, logic [4:0] cnt);
		int n, best;
		logic [31:0] sent[20];
		bit drp;
		if (kind == REQ_INSERT) begin
			drp = 1'b0;
			if (buf_fill < 20) begin
				buf_weight[buf_fill] = w;
				buf_age[buf_fill] = 4'd0;
				buf_fill++;
			end else begin
				drp = 1'b1;
			end
			queue_word(status_word(1'b0, 32'd0, 1'b1, drp));
			return;
		end
		n = cnt;
		if (n > buf_fill)
			n = buf_fill;
		for (int k = 0; k < n; k++) begin
			best = 0;
			for (int i = 1; i < buf_fill; i++)
				if (leaves_first(i, best))
					best = i;
			sent[k] = buf_weight[best];
			for (int i = best; i + 1 < buf_fill; i++) begin
				buf_weight[i] = buf_weight[i + 1];
				buf_age[i] = buf_age[i + 1];
			end
			buf_fill--;
		end
		for (int i = 0; i < buf_fill; i++)
			if (buf_age[i] < AGE_MAX)
				buf_age[i]++;
		if (n == 0)
			queue_word(status_word(1'b0, 32'd0, 1'b1, 1'b0));
		for (int k = 0; k < n; k++)
			queue_word(status_word(1'b1, sent[k], k == n - 1, 1'b0));
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_word_t got, want;
		if (!arst_n) begin
			buf_fill = 0;
			thr = THR_RST;
			smallest = 1'b1;
			fail_count = 0;
			task_results = 0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_AGE_THRESHOLD)
					thr = cfg_data;
				else
					smallest = cfg_data[0];
			end
			if (res_mon.valid && res_mon.ready) begin
				got = {res_mon.has_task, res_mon.out_weight, res_mon.last,
					res_mon.free_slots, res_mon.drop_count, res_mon.insert_dropped};
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", got.out_weight, 32'd0);
				end else begin
					want = expected_words.pop_front();
					if (got.has_task) task_results++;
					if (got.has_task !== want.has_task)
						report_mismatch("has_task", got.has_task, want.has_task);
					if (got.out_weight !== want.out_weight)
						report_mismatch("out_weight", got.out_weight, want.out_weight);
					if (got.last !== want.last)
						report_mismatch("last", got.last, want.last);
					if (got.free_slots !== want.free_slots)
						report_mismatch("free_slots", got.free_slots, want.free_slots);
					if (got.drop_count !== want.drop_count)
						report_mismatch("drop_count", got.drop_count, want.drop_count);
					if (got.insert_dropped !== want.insert_dropped)
						report_mismatch("insert_dropped", got.insert_dropped,
							want.insert_dropped);
				end
			end
			// Requests are predicted after results so one edge never mixes them up.
			if (req_mon.valid && req_mon.ready)
				predict_request(req_mon.req_type, req_mon.weight, req_mon.ready_count);
		end
	end
endmodule

FILE: tb/tb.sv
// Top of the task buffer testbench: clock, reset, configuration and request stimulus,
// result back-pressure and the verdict. Depends on apt_pkg, the interfaces and the checker.
module tb;
	import apt_pkg::*;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_we = 0;
	logic       cfg_idx = 0;
	logic [3:0] cfg_data = 0;
	int         fail_count, pending, task_results;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         sent_items = 0;

	apt_req_if req();
	apt_res_if res();

	aging_priority_task_buffer DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req(req.sink), .res(res.source)
	);

	aging_buffer_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req_mon(req.sink), .res_mon(res.sink),
		.fail_count(fail_count), .pending(pending), .task_results(task_results)
	);

	always #2 clk = ~clk;

	initial begin
		req.valid = 0;
		req.req_type = REQ_INSERT;
		req.weight = 0;
		req.ready_count = 0;
		res.ready = 0;
	end

	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Valid stays high between back-to-back words and drops only while idling.
	task automatic send_word(logic kind, logic [31:0] w, logic [4:0] cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1;
		req.req_type <= kind;
		req.weight <= w;
		req.ready_count <= cnt;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic drain;
		req.valid <= 0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (500) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return {16'($urandom_range(3)), 16'h0};
			default: return $urandom;
		endcase
	endfunction

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes, ties, empty dispatches.
		send_word(REQ_DISPATCH, 32'd0, 5'd0);
		send_word(REQ_DISPATCH, 32'd0, 5'd31);
		send_word(REQ_INSERT, 32'hFFFF_FFFF, 5'd0);
		send_word(REQ_INSERT, 32'h0, 5'd0);
		send_word(REQ_INSERT, 32'h0001_0000, 5'd0);
		send_word(REQ_INSERT, 32'h0001_0000, 5'd0);
		send_word(REQ_DISPATCH, 32'd0, 5'd0);
		send_word(REQ_DISPATCH, 32'd0, 5'd2);
		for (int i = 0; i < 12; i++)
			send_word(REQ_INSERT, $urandom, 5'd0);
		send_word(REQ_INSERT, 32'h1234_5678, 5'd0);
		send_word(REQ_DISPATCH, 32'd0, 5'd31);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 77; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 77; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			case (phase)
				0: begin
					write_reg(CFG_AGE_THRESHOLD, 4'd1);
					write_reg(CFG_SMALL_FIRST, 4'd0);
				end
				1: write_reg(CFG_AGE_THRESHOLD, 4'd15);
				2: begin
					write_reg(CFG_SMALL_FIRST, 4'd1);
					write_reg(CFG_AGE_THRESHOLD, 4'd0);
				end
				3: write_reg(CFG_AGE_THRESHOLD, 4'($urandom_range(1, 15)));
				4: write_reg(CFG_SMALL_FIRST, 4'b1110);
				5: write_reg(CFG_AGE_THRESHOLD, 4'd2);
				6: write_reg(CFG_SMALL_FIRST, 4'd1);
				default: write_reg(CFG_AGE_THRESHOLD, 4'd3);
			endcase
			for (int i = 0; i < 32; i++) begin
				if (i == 16) begin
					req.valid <= 0;
					@(negedge clk);
					while (pending != 0) @(negedge clk);
				end
				if ($urandom_range(99) < 72)
					send_word(REQ_INSERT, pick_weight(), 5'($urandom));
				else
					send_word(REQ_DISPATCH, $urandom,
						($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(4)));
			end
			drain();
		end

		$display("Sent %0d request words over 8 phases of idling and configuration;",
			sent_items);
		$display("%0d task words were dispatched and checked.", task_results);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/apt_pkg.sv
rtl/core/apt_req_if.sv
rtl/core/apt_res_if.sv
rtl/core/apt_front.sv
rtl/core/apt_fifo.sv
rtl/core/apt_back.sv
rtl/core/aging_priority_task_buffer.sv
tb/aging_buffer_checker.sv
tb/tb.sv
